FILE: sv/mpe_pkg.sv
// Shared types and constants for the modular exponentiation block.
package mpe_pkg;

    localparam int unsigned RES_W = 30;
    localparam logic [RES_W-1:0] MOD_P = 30'd998244353;
    localparam logic [31:0] MOD_P32 = 32'd998244353;
    localparam logic [31:0] MOD_2P32 = 32'd1996488706;
    localparam logic [31:0] MOD_3P32 = 32'd2994733059;
    localparam logic [31:0] MOD_4P32 = 32'd3992977412;
    // 2^32 mod MOD_P, weight of the high half of the base magnitude
    localparam logic [RES_W-1:0] FOLD_C = 30'd301989884;
    localparam logic [63:0] MU_FULL = 64'h1000_0000_0000_0000 / 64'd998244353;
    localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

    typedef enum logic [1:0] {
        DEST_ACC,
        DEST_SQ,
        DEST_BASE
    } dest_t;

    typedef struct packed {
        logic  valid;
        dest_t dest;
    } mm_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MUL,
        S_SQ,
        S_WAIT,
        S_DONE
    } state_t;

endpackage

FILE: sv/mpe_reduce.sv
// Base reduction into 0..MOD_P-1: split at bit 32, high half folded through the multiplier.
module mpe_reduce (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [63:0]        raw,
    output logic                      fold_req,
    output logic [mpe_pkg::RES_W-1:0] fold_op,
    input  logic                      fold_valid,
    input  logic [mpe_pkg::RES_W-1:0] fold_res,
    output logic                      done,
    output logic [mpe_pkg::RES_W-1:0] residue
);
    import mpe_pkg::*;

    logic [63:0]      mag_reg;
    logic             neg_reg;
    logic             split_reg;
    logic             req_reg;
    logic [RES_W-1:0] hi_reg;
    logic [RES_W-1:0] lo_reg;
    logic             sum_vld_reg;
    logic [RES_W-1:0] sum_reg;
    logic [RES_W-1:0] sum_next;
    logic             done_reg;
    logic [RES_W-1:0] residue_reg;
    logic [63:0]      raw_u;
    logic [RES_W:0]   add_c;
    logic [RES_W:0]   add_sub_c;

    function automatic logic [RES_W-1:0] mod32(input logic [31:0] x);
        logic [31:0] r;
        if (x >= MOD_4P32) begin
            r = x - MOD_4P32;
        end else if (x >= MOD_3P32) begin
            r = x - MOD_3P32;
        end else if (x >= MOD_2P32) begin
            r = x - MOD_2P32;
        end else if (x >= MOD_P32) begin
            r = x - MOD_P32;
        end else begin
            r = x;
        end
        return r[RES_W-1:0];
    endfunction

    assign raw_u     = raw;
    assign add_c     = {1'b0, fold_res} + {1'b0, lo_reg};
    assign add_sub_c = add_c - {1'b0, MOD_P};
    assign sum_next  = (add_c >= {1'b0, MOD_P}) ? add_sub_c[RES_W-1:0] : add_c[RES_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_reg   <= 1'b0;
            req_reg     <= 1'b0;
            sum_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            split_reg   <= start;
            req_reg     <= split_reg;
            sum_vld_reg <= fold_valid;
            done_reg    <= sum_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= raw_u[63] ? (~raw_u + 64'd1) : raw_u;
            neg_reg <= raw_u[63];
        end
        if (split_reg) begin
            hi_reg <= mod32(mag_reg[63:32]);
            lo_reg <= mod32(mag_reg[31:0]);
        end
        if (fold_valid) begin
            sum_reg <= sum_next;
        end
        if (sum_vld_reg) begin
            residue_reg <= (neg_reg && (sum_reg != '0)) ? (MOD_P - sum_reg) : sum_reg;
        end
    end

    assign fold_req = req_reg;
    assign fold_op  = hi_reg;
    assign done     = done_reg;
    assign residue  = residue_reg;

endmodule

FILE: sv/mpe_mulmod.sv
// Pipelined Barrett modular multiplier, one operation issued per cycle.
module mpe_mulmod (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mpe_pkg::mm_ctl_t          req,
    input  logic [mpe_pkg::RES_W-1:0] op_a,
    input  logic [mpe_pkg::RES_W-1:0] op_b,
    output mpe_pkg::mm_ctl_t          rsp,
    output logic [mpe_pkg::RES_W-1:0] result
);
    import mpe_pkg::*;

    mm_ctl_t          ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic [59:0]      prod1_reg;
    logic [31:0]      prod2_reg, prod3_reg;
    logic [61:0]      bm_reg;
    logic [31:0]      qp_reg;
    logic [31:0]      diff_reg;
    logic [RES_W-1:0] res_reg;
    logic [59:0]      prod_c;
    logic [61:0]      bm_c;
    logic [61:0]      qp_c;
    logic [31:0]      corr_c;

    assign prod_c = {30'd0, op_a} * {30'd0, op_b};
    assign bm_c   = {31'd0, prod1_reg[59:29]} * {31'd0, BARRETT_MU};
    assign qp_c   = {31'd0, bm_reg[61:31]} * {31'd0, MOD_P32[30:0]};

    always_comb begin
        if (diff_reg >= MOD_2P32) begin
            corr_c = diff_reg - MOD_2P32;
        end else if (diff_reg >= MOD_P32) begin
            corr_c = diff_reg - MOD_P32;
        end else begin
            corr_c = diff_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end else begin
            ctl1_reg <= req;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod1_reg <= prod_c;
        bm_reg    <= bm_c;
        prod2_reg <= prod1_reg[31:0];
        qp_reg    <= qp_c[31:0];
        prod3_reg <= prod2_reg;
        diff_reg  <= prod3_reg - qp_reg;
        res_reg   <= corr_c[RES_W-1:0];
    end

    assign rsp    = ctl5_reg;
    assign result = res_reg;

endmodule

FILE: sv/mod_prime_exponentiation.sv
// Top level: base^|exponent| mod 998244353 by right-to-left square-and-multiply.
//
// Input channel s_*: a signed 64-bit base and signed 64-bit exponent move in one
// transfer when s_valid and s_ready are both high. Output channel m_*: one
// 30-bit residue per input transfer, held in an output register until m_ready.
// The block works on one item at a time; s_ready is high only while idle.
// All modular products go through one shared 5-stage Barrett multiplier.
// An item first passes the base reduction (split at bit 32, one fold through
// the multiplier, add and sign fix) and the hand-off; each of the up to 64 bits
// of |exponent| then takes a multiply when the bit is set and a square issued
// back to back, then the wait for the square. s_ready returns in the same cycle
// as m_valid is set. The next item is taken while a result still waits in the
// output register; a stalled receiver blocks the input once a second result is
// ready. Reset is synchronous, active low, and clears the sequencer and valid
// flags; no state carries between items.
module mod_prime_exponentiation (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [63:0]        s_base_value,
    input  logic signed [63:0]        s_exponent,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [mpe_pkg::RES_W-1:0] m_power_residue
);
    import mpe_pkg::*;

    state_t           state_reg, state_next;
    logic [63:0]      e_reg;
    logic [RES_W-1:0] acc_reg;
    logic [RES_W-1:0] sq_reg;
    logic             m_valid_reg;
    logic [RES_W-1:0] m_res_reg;
    logic             s_xfer;
    logic             out_free;
    logic [63:0]      exp_u;
    logic             red_done;
    logic [RES_W-1:0] red_residue;
    logic             red_fold_req;
    logic [RES_W-1:0] red_fold_op;
    logic             red_fold_valid;
    mm_ctl_t          mm_req;
    mm_ctl_t          mm_rsp;
    logic [RES_W-1:0] mm_a, mm_b;
    logic [RES_W-1:0] mm_res;
    logic             finish;

    assign exp_u          = s_exponent;
    assign s_xfer         = s_valid && s_ready;
    assign out_free       = !m_valid_reg || m_ready;
    assign red_fold_valid = mm_rsp.valid && (mm_rsp.dest == DEST_BASE);

    mpe_reduce u_reduce (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_xfer),
        .raw        (s_base_value),
        .fold_req   (red_fold_req),
        .fold_op    (red_fold_op),
        .fold_valid (red_fold_valid),
        .fold_res   (mm_res),
        .done       (red_done),
        .residue    (red_residue)
    );

    mpe_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .rsp     (mm_rsp),
        .result  (mm_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (red_done) begin
                    state_next = (e_reg == '0) ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_SQ;
            end
            S_SQ: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (mm_rsp.valid && (mm_rsp.dest == DEST_SQ)) begin
                    state_next = (e_reg[63:1] == '0) ? S_DONE : S_MUL;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        mm_req  = '0;
        mm_a    = acc_reg;
        mm_b    = sq_reg;
        finish  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_REDUCE: begin
                mm_req.valid = red_fold_req;
                mm_req.dest  = DEST_BASE;
                mm_a         = red_fold_op;
                mm_b         = FOLD_C;
            end
            S_MUL: begin
                mm_req.valid = e_reg[0];
                mm_req.dest  = DEST_ACC;
            end
            S_SQ: begin
                mm_req.valid = 1'b1;
                mm_req.dest  = DEST_SQ;
                mm_a         = sq_reg;
            end
            S_DONE: begin
                finish = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            e_reg   <= exp_u[63] ? (~exp_u + 64'd1) : exp_u;
            acc_reg <= {{(RES_W-1){1'b0}}, 1'b1};
        end else begin
            if (mm_rsp.valid && (mm_rsp.dest == DEST_ACC)) begin
                acc_reg <= mm_res;
            end
            if (mm_rsp.valid && (mm_rsp.dest == DEST_SQ)) begin
                e_reg <= {1'b0, e_reg[63:1]};
            end
        end
        if (state_reg == S_REDUCE && red_done) begin
            sq_reg <= red_residue;
        end else if (mm_rsp.valid && (mm_rsp.dest == DEST_SQ)) begin
            sq_reg <= mm_res;
        end
        if (finish) begin
            m_res_reg <= acc_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_power_residue = m_res_reg;

endmodule

FILE: sv/mpe_checker.sv
// Port-level checker for the modular exponentiation block, bound to the top level.
module mpe_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [mpe_pkg::RES_W-1:0] m_power_residue
);
    import mpe_pkg::*;

    a_res_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_power_residue < MOD_P))
        else $error("result residue not below modulus");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_power_residue)))
        else $error("stalled result dropped or changed");

    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in work");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while block was idle");

endmodule

bind mod_prime_exponentiation mpe_checker u_mpe_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_power_residue (m_power_residue)
);

FILE: test/tb_mod_prime_exponentiation.sv
// Self-checking testbench for mod_prime_exponentiation: directed and random transfers.
module tb_mod_prime_exponentiation;
    timeunit 1ns;
    timeprecision 1ps;

    import mpe_pkg::*;

    localparam longint PRIME = 998244353;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int RANDOM_ITEMS = 1530;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef struct {
        logic signed [63:0] base_value;
        logic signed [63:0] exponent;
        logic [RES_W-1:0]   residue;
    } power_job_t;

    class residue_tracker;
        power_job_t  pending[$];
        int unsigned results_checked;
        int unsigned mismatches;

        function logic [RES_W-1:0] expected_power(logic [63:0] base_raw,
                                                  logic [63:0] exp_raw);
            longint unsigned p, sq, acc, e, r;
            p = longint'(PRIME);
            if (base_raw[63]) begin
                r = (64'd0 - base_raw) % p;
                sq = (r == 0) ? 64'd0 : p - r;
            end else begin
                sq = base_raw % p;
            end
            e = exp_raw[63] ? 64'd0 - exp_raw : exp_raw;
            acc = 1;
            while (e != 0) begin
                if (e[0])
                    acc = (acc * sq) % p;
                sq = (sq * sq) % p;
                e = e >> 1;
            end
            return acc[RES_W-1:0];
        endfunction

        function void note_input(logic signed [63:0] b, logic signed [63:0] e);
            power_job_t job;
            job.base_value = b;
            job.exponent = e;
            job.residue = expected_power(b, e);
            pending.insert(pending.size(), job);
        endfunction

        function void check_result(logic [RES_W-1:0] actual);
            power_job_t job;
            results_checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: residue %0d arrived with nothing outstanding", actual);
                return;
            end
            job = pending.pop_front();
            if (actual !== job.residue) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: base %0d exp %0d: expected %0d, got %0d",
                             job.base_value, job.exponent, job.residue, actual);
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [63:0]      s_base_value;
    logic signed [63:0]      s_exponent;
    logic                    m_valid;
    logic                    m_ready;
    logic [RES_W-1:0]        m_power_residue;

    residue_tracker sb;
    longint      cycle_count = 0;
    int          send_stretch;
    int unsigned items_sent;
    int unsigned full_width_exps;

    mod_prime_exponentiation dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_base_value    (s_base_value),
        .s_exponent      (s_exponent),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_power_residue (m_power_residue)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // runs of zero idle cycles now and then, otherwise 0..5
    function automatic int draw_idle(ref int stretch_left);
        if (stretch_left > 0) begin
            stretch_left--;
            return 0;
        end
        if ($urandom_range(39) == 0) begin
            stretch_left = $urandom_range(60, 20);
            return 0;
        end
        return $urandom_range(5);
    endfunction

    task automatic drive_item(input logic signed [63:0] base_in,
                              input logic signed [63:0] exp_in);
        int gap;
        gap = draw_idle(send_stretch);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_base_value <= base_in;
        s_exponent <= exp_in;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(base_in, exp_in);
        items_sent++;
    endtask

    initial begin : result_sink
        int stall;
        int stretch_left;
        bit held;
        stretch_left = 0;
        held = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            // one long stall so the block backs up into its input
            if (!held && sb.results_checked >= 400) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = draw_idle(stretch_left);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_power_residue);
        end
    end

    initial begin : watchdog
        @(posedge aclk);
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("ERROR: cycle limit reached");
        $display("mod_prime_exponentiation: mismatch");
        $finish;
    end

    initial begin : stimulus
        logic signed [63:0] b;
        logic signed [63:0] e;
        int w;
        sb = new();
        send_stretch = 0;
        items_sent = 0;
        full_width_exps = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_base_value <= '0;
        s_exponent <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        drive_item(0, 0);
        drive_item(PRIME, 0);
        drive_item(0, 1);
        drive_item(2, 10);
        drive_item(-1, 3);
        drive_item(-1, -3);
        drive_item(3, S64_MIN);
        drive_item(S64_MAX, S64_MAX);
        drive_item(S64_MIN, S64_MIN);
        drive_item(S64_MIN, 1);
        drive_item(S64_MAX, 1);
        drive_item(PRIME, 5);
        drive_item(-PRIME, 7);
        drive_item(PRIME * 64'sd9000000000, 3);
        drive_item(-PRIME * 64'sd9000000000, 1);
        drive_item(PRIME - 1, 2);
        drive_item(PRIME + 1, -1);
        drive_item(-(PRIME + 1), 1);
        drive_item(5, -1);
        drive_item(123456789, PRIME - 1);
        drive_item(-2, 64'hFFFF_FFFF_FFFF_FFFF);
        drive_item(1, S64_MAX);
        drive_item(0, S64_MIN);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: b = {$urandom, $urandom};
                4, 5:       b = longint'(int'($urandom_range(4000)) - 2000);
                6, 7:       b = PRIME * longint'(int'($urandom))
                                + longint'(int'($urandom_range(4)) - 2);
                default:    b = PRIME * longint'(int'($urandom_range(4)) - 2)
                                + longint'(int'($urandom_range(2)) - 1);
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    e = {$urandom, $urandom};
                    full_width_exps++;
                end
                9: begin
                    case ($urandom_range(4))
                        0: e = 0;
                        1: e = -1;
                        2: e = S64_MIN;
                        3: e = S64_MAX;
                        default: e = PRIME - 1;
                    endcase
                end
                default: begin
                    w = $urandom_range(20);
                    e = {$urandom, $urandom} >> (64 - w);
                    if ($urandom_range(3) == 0)
                        e = -e;
                end
            endcase
            drive_item(b, e);
            // let the pipeline run dry once mid-run
            if (items_sent == 900) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (sb.outstanding() != 0);
            end
        end
        s_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d transfers in, %0d residues checked, %0d full-width exponents,",
                 items_sent, sb.results_checked, full_width_exps);
        $display("plus one long output stall and one full drain of the input side.");
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("mod_prime_exponentiation: match");
        end else begin
            $display("%0d mismatches, %0d residues never arrived", sb.mismatches,
                     sb.outstanding());
            $display("mod_prime_exponentiation: mismatch");
        end
        $finish;
    end
endmodule
